// ----- hw/rtl/ntd_pkg.sv -----
// package for the nth prime trial division block: widths and sequencer states
`default_nettype none

package ntd_pkg;

  localparam int QUERY_WIDTH    = 15;
  localparam int IN_TDATA_WIDTH = 16;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_LOAD,
    S_DIV,
    S_DECIDE,
    S_APPEND,
    S_LOOKUP,
    S_LWAIT,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nth_prime_trial_division.sv -----
// top level: nth prime query server with a prime table grown by bit-serial trial division
//
//   channel  dir  handshake          tdata / tuser
//   s_*      in   s_tvalid/s_tready  tdata[14:0] query_index
//   m_*      out  m_tvalid/m_tready  tdata[PRIME_WIDTH-1:0] prime_value, tuser query_error
//
// after reset the S_INIT state stores 2 in the table before the first word is taken
// a query in the table: S_CHECK, S_LOOKUP, S_LWAIT, S_RESULT; an invalid query: S_RESULT
// each trial division: table read (S_FETCH), load, one remainder and square bit per
//   cycle in S_DIV, decide; each new candidate passes S_CHECK, each prime found
//   S_APPEND for the table write
// one query is served at a time; a stalled result waits in the output register
`default_nettype none

module nth_prime_trial_division #(
  parameter int TABLE_DEPTH = 16384,
  parameter int PRIME_WIDTH = 18
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [ntd_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,   // query_index
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [((PRIME_WIDTH+7)/8)*8-1:0]   m_tdata,   // prime_value
  output logic                               m_tuser    // query_error
);

  import ntd_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int PW   = PRIME_WIDTH;
  localparam int ODW  = ((PRIME_WIDTH + 7) / 8) * 8;
  localparam int CNTW = $clog2(PRIME_WIDTH);

  state_t state, state_next;

  logic [CW-1:0]          found, found_next;
  logic [PW-1:0]          last, last_next;
  logic [QUERY_WIDTH-1:0] qidx, qidx_next;
  logic [CW-1:0]          idx, idx_next;
  logic [PW-1:0]          cand, cand_next;
  logic [PW-1:0]          p, p_next;
  logic [PW-1:0]          csh, csh_next;
  logic [PW-1:0]          msh, msh_next;
  logic [PW-1:0]          rem, rem_next;
  logic [2*PW-1:0]        acc, acc_next;
  logic [CNTW-1:0]        cnt, cnt_next;
  logic [PW-1:0]          res_value, res_value_next;
  logic                   res_error, res_error_next;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [PW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [PW-1:0]          ram_rdata;

  logic [PW:0]            next_cand;
  logic [PW:0]            trial;
  logic [PW:0]            trial_diff;
  logic [31:0]            lookup_full;
  logic                   out_load;

  ntd_ram #(
    .WIDTH(PW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign next_cand   = {1'b0, last} + (PW+1)'(2);
  assign trial       = {rem, csh[PW-1]};
  assign trial_diff  = trial - {1'b0, p};
  assign lookup_full = 32'(qidx) - 32'd1;
  assign out_load    = (state == S_RESULT) && (!m_tvalid || m_tready);
  assign s_tready    = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      found <= '0;
      last  <= PW'(1);
    end else begin
      state <= state_next;
      found <= found_next;
      last  <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    qidx      <= qidx_next;
    idx       <= idx_next;
    cand      <= cand_next;
    p         <= p_next;
    csh       <= csh_next;
    msh       <= msh_next;
    rem       <= rem_next;
    acc       <= acc_next;
    cnt       <= cnt_next;
    res_value <= res_value_next;
    res_error <= res_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= ODW'(res_value);
      m_tuser <= res_error;
    end
  end

  always_comb begin
    state_next     = state;
    found_next     = found;
    last_next      = last;
    qidx_next      = qidx;
    idx_next       = idx;
    cand_next      = cand;
    p_next         = p;
    csh_next       = csh;
    msh_next       = msh;
    rem_next       = rem;
    acc_next       = acc;
    cnt_next       = cnt;
    res_value_next = res_value;
    res_error_next = res_error;
    ram_we         = 1'b0;
    ram_waddr      = found[AW-1:0];
    ram_wdata      = cand;
    ram_raddr      = idx[AW-1:0];

    unique case (state)
      S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = PW'(2);
        found_next = CW'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          qidx_next = s_tdata[QUERY_WIDTH-1:0];
          if ((s_tdata[QUERY_WIDTH-1:0] == '0) ||
              (32'(s_tdata[QUERY_WIDTH-1:0]) > 32'(TABLE_DEPTH))) begin
            res_value_next = '0;
            res_error_next = 1'b1;
            state_next     = S_RESULT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (32'(found) >= 32'(qidx)) begin
          state_next = S_LOOKUP;
        end else if (next_cand[PW]) begin
          // value range used up
          res_value_next = '0;
          res_error_next = 1'b1;
          state_next     = S_RESULT;
        end else begin
          cand_next  = next_cand[PW-1:0];
          last_next  = next_cand[PW-1:0];
          idx_next   = '0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ram_raddr = idx[AW-1:0];
        if (idx == found) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        p_next     = ram_rdata;
        msh_next   = ram_rdata;
        csh_next   = cand;
        rem_next   = '0;
        acc_next   = '0;
        cnt_next   = CNTW'(PRIME_WIDTH - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        // one remainder bit and one square bit per cycle
        if (trial >= {1'b0, p}) begin
          rem_next = trial_diff[PW-1:0];
        end else begin
          rem_next = trial[PW-1:0];
        end
        csh_next = {csh[PW-2:0], 1'b0};
        acc_next = {acc[2*PW-2:0], 1'b0} + (msh[PW-1] ? (2*PW)'(p) : '0);
        msh_next = {msh[PW-2:0], 1'b0};
        if (cnt == '0) begin
          state_next = S_DECIDE;
        end else begin
          cnt_next = cnt - CNTW'(1);
        end
      end
      S_DECIDE: begin
        priority if (acc > (2*PW)'(cand)) begin
          state_next = S_APPEND;
        end else if (rem == '0) begin
          state_next = S_CHECK;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_FETCH;
        end
      end
      S_APPEND: begin
        ram_we     = 1'b1;
        ram_waddr  = found[AW-1:0];
        ram_wdata  = cand;
        found_next = found + CW'(1);
        state_next = S_CHECK;
      end
      S_LOOKUP: begin
        ram_raddr  = lookup_full[AW-1:0];
        state_next = S_LWAIT;
      end
      S_LWAIT: begin
        res_value_next = ram_rdata;
        res_error_next = 1'b0;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (found != '0) && (32'(found) <= 32'(TABLE_DEPTH)))
    else $error("table count out of range");

  a_append_needed: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> (32'(found) < 32'(qidx)))
    else $error("table grown past the query");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < p))
    else $error("remainder not below divisor");

  a_candidate_odd: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> last[0])
    else $error("even candidate");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error word with nonzero value");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ntd_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module ntd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16384
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
